// ===== sv/llca_pkg.sv =====
// ----------------------------------------------------------------------------
// llca_pkg: shared types and constants of the life-like automaton core
// Item structs, register indexes, reset values and the neighbor offsets.
// ----------------------------------------------------------------------------
package llca_pkg;

  // Default grid limits handed to the top-level parameters.
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int RULE_W      = 18;
  localparam int SIZE_REG_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_RULE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd2;

  localparam logic [RULE_W-1:0]     RULE_RESET = 18'h01808;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;

  // The channel value that counts as alive and is returned for alive, and the value returned for dead.
  localparam logic [7:0] FULL_VALUE = 8'd255;
  localparam logic [7:0] DEAD_VALUE = 8'd0;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_EVAL = 1'b1;

  // Row and column offsets of the eight neighbors.
  localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                              2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] NB_DC [8] = '{2'sd1, 2'sd1, 2'sd1, 2'sd0,
                                              2'sd0, -2'sd1, -2'sd1, -2'sd1};

  typedef struct packed {
    logic [0:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_in_t;

  typedef struct packed {
    logic [7:0] next_red;
    logic [7:0] next_green;
    logic [7:0] next_blue;
  } cell_out_t;

endpackage

// ===== sv/llca_ram.sv =====
// ----------------------------------------------------------------------------
// llca_ram: generic single-port synchronous RAM
// One read or write address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module llca_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/life_like_ca_cell_update_core.sv =====
// ----------------------------------------------------------------------------
// life_like_ca_cell_update_core: life-like automaton on a three-plane torus
// Load items fill a cell store; evaluate items return the next cell state.
// ----------------------------------------------------------------------------
// Load item: the cell is written in WRITE, then the core is idle again.
// Evaluate item: nine reads of the single-port cell memory in READ, then DRAIN
// and FINISH; the result register is loaded in FINISH once it is free, and the
// next item can be accepted after that. A row or column outside the grid in
// use adds the DIV state for the bit-serial remainder unit. Reset clears
// control and configuration; the cell memory is not cleared.
module life_like_ca_cell_update_core #(
  parameter int MAX_ROWS = llca_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = llca_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input items.
  input  logic                               cell_valid,
  output logic                               cell_stall,
  input  llca_pkg::cell_in_t                 cell_item,
  // Result items.
  output logic                               res_valid,
  input  logic                               res_stall,
  output llca_pkg::cell_out_t                res_item,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [llca_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [llca_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import llca_pkg::*;

  // Coordinate width, effective grid size width and memory address width.
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [3:0] LAST_TAP = 4'd8;

  // Configuration registers. The user must write them only while the core is
  // idle; the block itself does not enforce this, and writes are always taken.
  logic [RULE_W-1:0]     rule_mask;
  logic [SIZE_REG_W-1:0] grid_rows;
  logic [SIZE_REG_W-1:0] grid_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mask <= RULE_RESET;
      grid_rows <= SIZE_RESET;
      grid_cols <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RULE_MASK: rule_mask <= cfg_data[RULE_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[SIZE_REG_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg_data[SIZE_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective grid size: zero counts as one, and the size saturates at the
  // store's limit.
  logic [RSW-1:0] rows_eff;
  logic [CSW-1:0] cols_eff;

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = RSW'(1);
    end else if (int'(grid_rows) > MAX_ROWS) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = CSW'(1);
    end else if (int'(grid_cols) > MAX_COLS) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(grid_cols);
    end
  end

  // Sequencer and item registers.
  logic [2:0]     state;
  logic [3:0]     tap;
  logic [2:0]     div_cnt;
  logic [0:0]     op;
  logic [RW-1:0]  r;
  logic [CW-1:0]  c;
  logic [2:0]     load_bits;
  logic [7:0]     div_row;
  logic [7:0]     div_col;
  logic [RSW-1:0] rem_row;
  logic [CSW-1:0] rem_col;
  logic           rd_pend;
  logic           rd_self;
  logic [2:0]     self_bits;
  logic [3:0]     cnt [3];

  logic accept;
  logic in_range;
  logic slot_free;

  assign cell_stall = (state != S_IDLE);
  assign accept     = cell_valid && !cell_stall;
  assign in_range   = (int'(cell_item.row) < int'(rows_eff)) &&
                      (int'(cell_item.col) < int'(cols_eff));
  // The result register can take a new item when empty or being emptied.
  assign slot_free  = !res_valid || !res_stall;

  // One restoring remainder step per cycle for row and column in parallel.
  logic [RSW:0]   trial_row;
  logic [CSW:0]   trial_col;
  logic [RSW-1:0] rem_row_next;
  logic [CSW-1:0] rem_col_next;

  always_comb begin
    trial_row = {rem_row, div_row[7]};
    trial_col = {rem_col, div_col[7]};
    if (trial_row >= {1'b0, rows_eff}) begin
      rem_row_next = RSW'(trial_row - {1'b0, rows_eff});
    end else begin
      rem_row_next = RSW'(trial_row);
    end
    if (trial_col >= {1'b0, cols_eff}) begin
      rem_col_next = CSW'(trial_col - {1'b0, cols_eff});
    end else begin
      rem_col_next = CSW'(trial_col);
    end
  end

  // Coordinates of the current tap. Tap zero is the cell itself and taps one
  // to eight are its neighbors, wrapped on the torus.
  logic signed [1:0] dr;
  logic signed [1:0] dc;
  logic [2:0]        nb_idx;
  logic [RW-1:0]     nr;
  logic [CW-1:0]     nc;
  logic [AW-1:0]     addr;

  always_comb begin
    nb_idx = 3'(tap - 4'd1);
    if (tap == '0) begin
      dr = 2'sd0;
      dc = 2'sd0;
    end else begin
      dr = NB_DR[nb_idx];
      dc = NB_DC[nb_idx];
    end

    // The sign bit marks a step back, the low bit alone a step forward.
    if (dr[1]) begin
      nr = (r == '0) ? RW'(rows_eff - RSW'(1)) : r - RW'(1);
    end else if (dr[0]) begin
      nr = (RSW'(r) == rows_eff - RSW'(1)) ? '0 : r + RW'(1);
    end else begin
      nr = r;
    end
    if (dc[1]) begin
      nc = (c == '0) ? CW'(cols_eff - CSW'(1)) : c - CW'(1);
    end else if (dc[0]) begin
      nc = (CSW'(c) == cols_eff - CSW'(1)) ? '0 : c + CW'(1);
    end else begin
      nc = c;
    end

    addr = AW'(nr) * AW'(MAX_COLS) + AW'(nc);
  end

  // Cell store: bit 0 red, bit 1 green, bit 2 blue.
  logic       mem_we;
  logic [2:0] mem_rdata;

  assign mem_we = (state == S_WRITE);

  llca_ram #(
    .WIDTH(3),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (addr),
    .wdata(load_bits),
    .rdata(mem_rdata)
  );

  // Rule lookup: bit 9*alive+count of the rule mask decides each channel.
  logic [4:0]  rule_idx [3];
  logic [2:0]  next_bits;
  cell_out_t   res_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rule_idx[k]  = self_bits[k] ? 5'd9 + 5'(cnt[k]) : 5'(cnt[k]);
      next_bits[k] = rule_mask[rule_idx[k]];
    end
    res_next.next_red   = next_bits[0] ? FULL_VALUE : DEAD_VALUE;
    res_next.next_green = next_bits[1] ? FULL_VALUE : DEAD_VALUE;
    res_next.next_blue  = next_bits[2] ? FULL_VALUE : DEAD_VALUE;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap       <= '0;
      div_cnt   <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      // A finished item fills the result register as soon as it is free.
      if (state == S_FINISH && slot_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          tap     <= '0;
          div_cnt <= '0;
          if (accept) begin
            if (!in_range) begin
              state <= S_DIV;
            end else if (cell_item.op == OP_LOAD) begin
              state <= S_WRITE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            state <= (op == OP_LOAD) ? S_WRITE : S_READ;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_READ: begin
          tap <= tap + 4'd1;
          if (tap == LAST_TAP) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload, remainder unit and neighbor counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= cell_item.op;
      r         <= RW'(cell_item.row);
      c         <= CW'(cell_item.col);
      load_bits <= {cell_item.blue == FULL_VALUE,
                    cell_item.green == FULL_VALUE,
                    cell_item.red == FULL_VALUE};
      div_row   <= cell_item.row;
      div_col   <= cell_item.col;
      rem_row   <= '0;
      rem_col   <= '0;
      self_bits <= '0;
      for (int k = 0; k < 3; k++) begin
        cnt[k] <= '0;
      end
    end

    if (state == S_DIV) begin
      rem_row <= rem_row_next;
      rem_col <= rem_col_next;
      div_row <= {div_row[6:0], 1'b0};
      div_col <= {div_col[6:0], 1'b0};
      if (div_cnt == 3'd7) begin
        r <= RW'(rem_row_next);
        c <= CW'(rem_col_next);
      end
    end

    // Read data lands in the cycle after its address; tap zero is the cell.
    rd_self <= (tap == '0);
    if (rd_pend) begin
      if (rd_self) begin
        self_bits <= mem_rdata;
      end else begin
        for (int k = 0; k < 3; k++) begin
          cnt[k] <= cnt[k] + 4'(mem_rdata[k]);
        end
      end
    end

    if (state == S_FINISH && slot_free) begin
      res_item <= res_next;
    end
  end

endmodule
